// ----- rtl/ecss_pkg.sv -----
`default_nettype none
package ecss_pkg;

  typedef enum logic [2:0] {
    KIND_INTAKE     = 3'd0,
    KIND_EXHAUST    = 3'd1,
    KIND_LONG_TOOTH = 3'd2,
    KIND_EVALUATE   = 3'd3,
    KIND_STOP       = 3'd4,
    KIND_CRANK_OFF  = 3'd5,
    KIND_MID_CHECK  = 3'd6
  } kind_t;

  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_MATCH_WINDOW       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCURATE_THRESHOLD = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COARSE_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_INTAKE_REFS        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_EXHAUST_REFS       = 3'd4;

  localparam int unsigned REF_COUNT_DEFAULT = 6;
  localparam int unsigned REF_W             = 10;
  localparam int unsigned REFS_PACKED       = 6;
  localparam int unsigned REFS_W            = REF_W * REFS_PACKED;

  localparam int unsigned ANGLE_W  = 16;
  localparam int unsigned IDX_W    = 7;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned STOPPOS_W = 8;

  localparam logic [ANGLE_W:0]     EDGE_ROUND = 17'd192;
  localparam logic [IDX_W-1:0]     EDGE_CAP   = 7'd120;
  localparam logic [STOPPOS_W-1:0] STOP_CAP   = 8'd240;
  localparam logic [CNT_W-1:0]     CNT_LAST   = 8'd254;
  localparam logic [19:0]          DIV3_RECIP = 20'd683;

  // x / 3 for 10-bit x: (x * 683) >> 11 is exact below 1024
  function automatic logic [9:0] div3(input logic [9:0] x);
    logic [19:0] prod;
    prod = 20'(x) * DIV3_RECIP;
    return {1'b0, prod[19:11]};
  endfunction

endpackage
`default_nettype wire

// ----- rtl/engine_cam_sync_status.sv -----
// An input item is first held in the input register; its result then moves into the result
// register, which drives out_valid and the result outputs.
// Throughput: one item per cycle while the result register is empty or out_ready is high;
// a held result with out_ready low stalls the input register, and in_ready follows out_ready.
// Reset: synchronous active-low rst_n clears handshakes, counters, sync and stop state
// and the configuration registers; the configuration port is always ready.
`default_nettype none
module engine_cam_sync_status #(
  parameter int unsigned REF_COUNT = ecss_pkg::REF_COUNT_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,

  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [ecss_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [ecss_pkg::REFS_W-1:0]      cfg_data,

  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [2:0]                       in_kind,
  input  wire logic [ecss_pkg::ANGLE_W-1:0]     in_angle_raw,
  input  wire logic                             in_crank_fault,
  input  wire logic                             in_position_ok,
  input  wire logic                             in_inhibit_fault,
  input  wire logic                             in_force_unsync,

  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [ecss_pkg::IDX_W-1:0]            out_edge_angle_index,
  output logic                                  out_edge_matched,
  output logic [ecss_pkg::CNT_W-1:0]            out_intake_match_count,
  output logic [ecss_pkg::CNT_W-1:0]            out_exhaust_match_count,
  output logic                                  out_sync_accurate,
  output logic                                  out_sync_coarse,
  output logic                                  out_accurate_rise,
  output logic                                  out_coarse_rise,
  output logic                                  out_stop_valid,
  output logic                                  out_stop_seen,
  output logic [ecss_pkg::STOPPOS_W-1:0]        out_stop_position
);

  localparam int unsigned RW = ecss_pkg::REF_W;

  // configuration
  logic [7:0]                  match_window_r;
  logic [7:0]                  acc_thr_r;
  logic [7:0]                  crs_thr_r;
  logic [ecss_pkg::REFS_W-1:0] intake_refs_r;
  logic [ecss_pkg::REFS_W-1:0] exhaust_refs_r;

  // input register
  logic                            s1_valid_r;
  ecss_pkg::kind_t                 s1_kind_r;
  logic [ecss_pkg::IDX_W-1:0]      s1_idx_r;
  logic                            s1_crank_fault_r;
  logic                            s1_pos_ok_r;
  logic                            s1_clear_req_r;
  logic [ecss_pkg::STOPPOS_W-1:0]  s1_stop_pos_r;

  // tracker state
  logic [ecss_pkg::CNT_W-1:0]     intake_cnt_r, intake_cnt_nxt;
  logic [ecss_pkg::CNT_W-1:0]     exhaust_cnt_r, exhaust_cnt_nxt;
  logic                           long_tooth_r, long_tooth_nxt;
  logic                           acc_r, acc_nxt;
  logic                           crs_r, crs_nxt;
  logic                           stop_valid_r, stop_valid_nxt;
  logic                           stop_seen_r, stop_seen_nxt;
  logic [ecss_pkg::STOPPOS_W-1:0] stop_pos_r, stop_pos_nxt;

  logic out_valid_r;
  logic advance;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;

  // ---- input side: edge rounding and stop position ----
  logic [ecss_pkg::ANGLE_W:0]     round_sum;
  logic [9:0]                     edge_q;
  logic [9:0]                     stop_q;
  logic [ecss_pkg::IDX_W-1:0]     idx_in;
  logic [ecss_pkg::STOPPOS_W-1:0] stop_pos_in;
  logic                           is_edge_in;

  always_comb begin
    round_sum   = {1'b0, in_angle_raw} + ecss_pkg::EDGE_ROUND;
    // /384 = >>7 then /3
    edge_q      = ecss_pkg::div3(round_sum[ecss_pkg::ANGLE_W:7]);
    // /192 = >>6 then /3
    stop_q      = ecss_pkg::div3(in_angle_raw[ecss_pkg::ANGLE_W-1:6]);
    is_edge_in  = (in_kind == ecss_pkg::KIND_INTAKE) || (in_kind == ecss_pkg::KIND_EXHAUST);
    if (!is_edge_in) begin
      idx_in = '0;
    end else if (edge_q > 10'(ecss_pkg::EDGE_CAP)) begin
      idx_in = ecss_pkg::EDGE_CAP;
    end else begin
      idx_in = edge_q[ecss_pkg::IDX_W-1:0];
    end
    if (stop_q > 10'(ecss_pkg::STOP_CAP)) begin
      stop_pos_in = ecss_pkg::STOP_CAP;
    end else begin
      stop_pos_in = stop_q[ecss_pkg::STOPPOS_W-1:0];
    end
  end

  // ---- reference match ----
  logic [ecss_pkg::REFS_W-1:0] refs_sel;
  logic [RW-1:0]               edge_pos;
  logic [RW-1:0]               ref_val [REF_COUNT];
  logic [REF_COUNT-1:0]        ref_hit;
  logic                        s1_is_edge;
  logic                        matched;

  assign s1_is_edge = (s1_kind_r == ecss_pkg::KIND_INTAKE) ||
                      (s1_kind_r == ecss_pkg::KIND_EXHAUST);
  assign refs_sel   = (s1_kind_r == ecss_pkg::KIND_INTAKE) ? intake_refs_r : exhaust_refs_r;
  assign edge_pos   = {1'b0, s1_idx_r, 2'b00} + {2'b00, s1_idx_r, 1'b0};

  for (genvar gi = 0; gi < REF_COUNT; gi++) begin : g_ref
    logic [RW-1:0] diff;
    if (gi < ecss_pkg::REFS_PACKED) begin : g_packed
      assign ref_val[gi] = refs_sel[gi*RW +: RW];
    end else begin : g_zero
      assign ref_val[gi] = '0;
    end
    assign diff        = (edge_pos >= ref_val[gi]) ? edge_pos - ref_val[gi]
                                                   : ref_val[gi] - edge_pos;
    assign ref_hit[gi] = diff < {2'b00, match_window_r};
  end

  assign matched = s1_is_edge && (|ref_hit);

  // ---- state update for the item in the input register ----
  always_comb begin
    intake_cnt_nxt  = intake_cnt_r;
    exhaust_cnt_nxt = exhaust_cnt_r;
    long_tooth_nxt  = long_tooth_r;
    acc_nxt         = acc_r;
    crs_nxt         = crs_r;
    stop_valid_nxt  = stop_valid_r;
    stop_seen_nxt   = stop_seen_r;
    stop_pos_nxt    = stop_pos_r;
    unique case (s1_kind_r)
      ecss_pkg::KIND_INTAKE: begin
        if (matched) begin
          intake_cnt_nxt = (intake_cnt_r == ecss_pkg::CNT_LAST) ? '0 : intake_cnt_r + 1'b1;
        end
      end
      ecss_pkg::KIND_EXHAUST: begin
        if (matched) begin
          exhaust_cnt_nxt = (exhaust_cnt_r == ecss_pkg::CNT_LAST) ? '0 : exhaust_cnt_r + 1'b1;
        end
      end
      ecss_pkg::KIND_LONG_TOOTH: begin
        long_tooth_nxt = 1'b1;
      end
      ecss_pkg::KIND_EVALUATE: begin
        acc_nxt = long_tooth_r || (intake_cnt_r >= acc_thr_r) || (exhaust_cnt_r >= acc_thr_r);
        crs_nxt = acc_nxt || long_tooth_r || stop_valid_r ||
                  (intake_cnt_r >= crs_thr_r) || (exhaust_cnt_r >= crs_thr_r);
      end
      ecss_pkg::KIND_STOP: begin
        stop_valid_nxt = !s1_crank_fault_r && acc_r && s1_pos_ok_r;
        stop_seen_nxt  = 1'b1;
        stop_pos_nxt   = s1_stop_pos_r;
      end
      ecss_pkg::KIND_CRANK_OFF, ecss_pkg::KIND_MID_CHECK: begin
        // mid check clears only on a fault or a force request
        if (s1_kind_r == ecss_pkg::KIND_CRANK_OFF || s1_clear_req_r) begin
          long_tooth_nxt  = 1'b0;
          acc_nxt         = 1'b0;
          crs_nxt         = 1'b0;
          intake_cnt_nxt  = '0;
          exhaust_cnt_nxt = '0;
        end
      end
      default: begin
      end
    endcase
  end

  // ---- registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_window_r <= '0;
      acc_thr_r      <= '0;
      crs_thr_r      <= '0;
      intake_refs_r  <= '0;
      exhaust_refs_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ecss_pkg::REG_MATCH_WINDOW:       match_window_r <= cfg_data[7:0];
        ecss_pkg::REG_ACCURATE_THRESHOLD: acc_thr_r      <= cfg_data[7:0];
        ecss_pkg::REG_COARSE_THRESHOLD:   crs_thr_r      <= cfg_data[7:0];
        ecss_pkg::REG_INTAKE_REFS:        intake_refs_r  <= cfg_data;
        ecss_pkg::REG_EXHAUST_REFS:       exhaust_refs_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind_r        <= ecss_pkg::kind_t'(in_kind);
      s1_idx_r         <= idx_in;
      s1_crank_fault_r <= in_crank_fault;
      s1_pos_ok_r      <= in_position_ok;
      s1_clear_req_r   <= in_inhibit_fault || in_force_unsync;
      s1_stop_pos_r    <= stop_pos_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intake_cnt_r  <= '0;
      exhaust_cnt_r <= '0;
      long_tooth_r  <= 1'b0;
      acc_r         <= 1'b0;
      crs_r         <= 1'b0;
      stop_valid_r  <= 1'b0;
      stop_seen_r   <= 1'b0;
      stop_pos_r    <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (advance) begin
        intake_cnt_r  <= intake_cnt_nxt;
        exhaust_cnt_r <= exhaust_cnt_nxt;
        long_tooth_r  <= long_tooth_nxt;
        acc_r         <= acc_nxt;
        crs_r         <= crs_nxt;
        stop_valid_r  <= stop_valid_nxt;
        stop_seen_r   <= stop_seen_nxt;
        stop_pos_r    <= stop_pos_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  // flags only move on items, so the flag before this item is the previous one
  always_ff @(posedge clk) begin
    if (advance) begin
      out_edge_angle_index    <= s1_idx_r;
      out_edge_matched        <= matched;
      out_intake_match_count  <= intake_cnt_nxt;
      out_exhaust_match_count <= exhaust_cnt_nxt;
      out_sync_accurate       <= acc_nxt;
      out_sync_coarse         <= crs_nxt;
      out_accurate_rise       <= acc_nxt && !acc_r;
      out_coarse_rise         <= crs_nxt && !crs_r;
      out_stop_valid          <= stop_valid_nxt;
      out_stop_seen           <= stop_seen_nxt;
      out_stop_position       <= stop_pos_nxt;
    end
  end

`ifndef SYNTH
  a_cnt_no_255: assert property (@(posedge clk) disable iff (!rst_n)
    (intake_cnt_r != 8'd255) && (exhaust_cnt_r != 8'd255))
    else $error("match count reached 255");

  a_acc_implies_crs: assert property (@(posedge clk) disable iff (!rst_n)
    acc_r |-> crs_r)
    else $error("accurate sync without coarse sync");

  a_rise_has_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_accurate_rise) |-> out_sync_accurate)
    else $error("accurate rise pulse without accurate flag");

  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while both stages are stalled");

  a_state_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> ($stable(intake_cnt_r) && $stable(exhaust_cnt_r) && $stable(acc_r)))
    else $error("tracker state moved without an item");
`endif

endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`default_nettype none
module tb_top;

  localparam int unsigned IDX_W       = ecss_pkg::IDX_W;
  localparam int unsigned CNT_W       = ecss_pkg::CNT_W;
  localparam int unsigned STOPPOS_W   = ecss_pkg::STOPPOS_W;
  localparam int unsigned CFG_IDX_W   = ecss_pkg::CFG_IDX_W;
  localparam int unsigned REFS_W      = ecss_pkg::REFS_W;
  localparam int unsigned ANGLE_W     = ecss_pkg::ANGLE_W;
  localparam int unsigned REF_W       = ecss_pkg::REF_W;
  localparam int unsigned REFS_PACKED = ecss_pkg::REFS_PACKED;

  localparam logic [2:0] KIND_UNUSED = 3'd7;
  localparam int LONG_HOLD  = 150;
  localparam int IDLE_LIMIT = 2000;
  localparam int SETTLE     = 4;
  localparam int DIR_LEN    = 30;

  typedef enum int { MIX_GENERAL, MIX_EDGE_RUN } mix_t;

  typedef struct packed {
    logic [IDX_W-1:0]     edge_idx;
    logic                 matched;
    logic [CNT_W-1:0]     intake_cnt;
    logic [CNT_W-1:0]     exhaust_cnt;
    logic                 accurate;
    logic                 coarse;
    logic                 accurate_rise;
    logic                 coarse_rise;
    logic                 stop_valid;
    logic                 stop_seen;
    logic [STOPPOS_W-1:0] stop_pos;
  } cam_status_t;

  // flags: crank_fault, position_ok, inhibit_fault, force_unsync
  typedef struct packed {
    logic                 is_reg;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [REFS_W-1:0]    reg_val;
    logic [2:0]           kind;
    logic [ANGLE_W-1:0]   angle;
    logic [3:0]           flags;
    logic                 typed;
    cam_status_t          want;
  } dir_step_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid, cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REFS_W-1:0] cfg_data;
  logic in_valid, in_ready;
  logic [2:0] in_kind;
  logic [ANGLE_W-1:0] in_angle_raw;
  logic in_crank_fault, in_position_ok, in_inhibit_fault, in_force_unsync;
  logic out_valid, out_ready;
  logic [IDX_W-1:0] out_edge_angle_index;
  logic out_edge_matched;
  logic [CNT_W-1:0] out_intake_match_count, out_exhaust_match_count;
  logic out_sync_accurate, out_sync_coarse, out_accurate_rise, out_coarse_rise;
  logic out_stop_valid, out_stop_seen;
  logic [STOPPOS_W-1:0] out_stop_position;

  always #5 clk = ~clk;

  engine_cam_sync_status u_top (
    .clk                     (clk),
    .rst_n                   (rst_n),
    .cfg_valid               (cfg_valid),
    .cfg_ready               (cfg_ready),
    .cfg_index               (cfg_index),
    .cfg_data                (cfg_data),
    .in_valid                (in_valid),
    .in_ready                (in_ready),
    .in_kind                 (in_kind),
    .in_angle_raw            (in_angle_raw),
    .in_crank_fault          (in_crank_fault),
    .in_position_ok          (in_position_ok),
    .in_inhibit_fault        (in_inhibit_fault),
    .in_force_unsync         (in_force_unsync),
    .out_valid               (out_valid),
    .out_ready               (out_ready),
    .out_edge_angle_index    (out_edge_angle_index),
    .out_edge_matched        (out_edge_matched),
    .out_intake_match_count  (out_intake_match_count),
    .out_exhaust_match_count (out_exhaust_match_count),
    .out_sync_accurate       (out_sync_accurate),
    .out_sync_coarse         (out_sync_coarse),
    .out_accurate_rise       (out_accurate_rise),
    .out_coarse_rise         (out_coarse_rise),
    .out_stop_valid          (out_stop_valid),
    .out_stop_seen           (out_stop_seen),
    .out_stop_position       (out_stop_position)
  );

  // predictor copy of the registers and the tracker state
  logic [7:0]        win_cfg, acc_thr_cfg, crs_thr_cfg;
  logic [REFS_W-1:0] intake_refs_cfg, exhaust_refs_cfg;
  logic [CNT_W-1:0]  intake_cnt, exhaust_cnt;
  logic              long_tooth, acc_flag, crs_flag, stop_ok, stop_hit;
  logic              acc_was, crs_was;
  logic [STOPPOS_W-1:0] stop_pos;

  cam_status_t pending_status [$];
  dir_step_t   dir_steps [DIR_LEN];

  int fail_count, n_items, n_results, n_matched, n_wraps, n_acc_rise;
  bit send_calm, rx_calm, hold_req;

  task automatic flag_mismatch(string what);
    $display("%0t: %s", $time, what);
    fail_count++;
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] want);
    if (got !== want)
      flag_mismatch($sformatf("%s got %0d want %0d", name, got, want));
  endtask

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(12, 40) : $urandom_range(1, 3);
  endfunction

  function automatic logic near_reference(logic [IDX_W-1:0] idx, logic [REFS_W-1:0] refs);
    int pos, ref_angle, delta;
    pos = 6 * int'(idx);
    for (int i = 0; i < REFS_PACKED; i++) begin
      ref_angle = int'(refs[REF_W*i +: REF_W]);
      delta = (pos >= ref_angle) ? pos - ref_angle : ref_angle - pos;
      if (delta < int'(win_cfg))
        return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [CNT_W-1:0] bump_count(logic [CNT_W-1:0] cnt);
    if (cnt == 8'd254) begin
      n_wraps++;
      return '0;
    end
    return cnt + 8'd1;
  endfunction

  function automatic void clear_sync_state();
    long_tooth  = 1'b0;
    acc_flag    = 1'b0;
    crs_flag    = 1'b0;
    intake_cnt  = '0;
    exhaust_cnt = '0;
  endfunction

  function automatic cam_status_t predict_status(logic [2:0] kind, logic [ANGLE_W-1:0] angle,
                                                 logic [3:0] flags);
    cam_status_t s;
    logic [ANGLE_W:0] rounded;
    logic [ANGLE_W-1:0] quot;
    s = '0;
    case (kind)
      ecss_pkg::KIND_INTAKE, ecss_pkg::KIND_EXHAUST: begin
        rounded = ({1'b0, angle} + ecss_pkg::EDGE_ROUND) / 17'd384;
        s.edge_idx = (rounded > 17'd120) ? ecss_pkg::EDGE_CAP : rounded[IDX_W-1:0];
        s.matched = near_reference(s.edge_idx, (kind == ecss_pkg::KIND_INTAKE) ?
                                               intake_refs_cfg : exhaust_refs_cfg);
        if (s.matched) begin
          n_matched++;
          if (kind == ecss_pkg::KIND_INTAKE)
            intake_cnt = bump_count(intake_cnt);
          else
            exhaust_cnt = bump_count(exhaust_cnt);
        end
      end
      ecss_pkg::KIND_LONG_TOOTH: long_tooth = 1'b1;
      ecss_pkg::KIND_EVALUATE: begin
        acc_flag = long_tooth || intake_cnt >= acc_thr_cfg || exhaust_cnt >= acc_thr_cfg;
        crs_flag = acc_flag || long_tooth || stop_ok ||
                   intake_cnt >= crs_thr_cfg || exhaust_cnt >= crs_thr_cfg;
      end
      ecss_pkg::KIND_STOP: begin
        quot = angle / 16'd192;
        stop_ok  = !flags[3] && acc_flag && flags[2];
        stop_hit = 1'b1;
        stop_pos = (quot > 16'd240) ? ecss_pkg::STOP_CAP : quot[STOPPOS_W-1:0];
      end
      ecss_pkg::KIND_CRANK_OFF: clear_sync_state();
      ecss_pkg::KIND_MID_CHECK: if (flags[1] || flags[0]) clear_sync_state();
      default: ;
    endcase
    s.accurate_rise = acc_flag && !acc_was;
    s.coarse_rise   = crs_flag && !crs_was;
    if (s.accurate_rise) n_acc_rise++;
    acc_was = acc_flag;
    crs_was = crs_flag;
    s.intake_cnt  = intake_cnt;
    s.exhaust_cnt = exhaust_cnt;
    s.accurate    = acc_flag;
    s.coarse      = crs_flag;
    s.stop_valid  = stop_ok;
    s.stop_seen   = stop_hit;
    s.stop_pos    = stop_pos;
    return s;
  endfunction

  task automatic settle_pipeline();
    in_valid <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REFS_W-1:0] val);
    settle_pipeline();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      ecss_pkg::REG_MATCH_WINDOW:       win_cfg = val[7:0];
      ecss_pkg::REG_ACCURATE_THRESHOLD: acc_thr_cfg = val[7:0];
      ecss_pkg::REG_COARSE_THRESHOLD:   crs_thr_cfg = val[7:0];
      ecss_pkg::REG_INTAKE_REFS:        intake_refs_cfg = val;
      ecss_pkg::REG_EXHAUST_REFS:       exhaust_refs_cfg = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic send_item(logic [2:0] kind, logic [ANGLE_W-1:0] angle, logic [3:0] flags,
                           logic typed, cam_status_t want);
    int gap;
    cam_status_t predicted;
    if (n_items % 32 == 0)
      send_calm = ($urandom_range(0, 3) == 0);
    gap = (!send_calm && $urandom_range(0, 2) == 0) ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_angle_raw     <= angle;
    in_crank_fault   <= flags[3];
    in_position_ok   <= flags[2];
    in_inhibit_fault <= flags[1];
    in_force_unsync  <= flags[0];
    do @(posedge clk); while (!in_ready);
    predicted = predict_status(kind, angle, flags);
    pending_status.push_back(typed ? want : predicted);
    n_items++;
  endtask

  function automatic logic [2:0] pick_kind(mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    if (mix == MIX_EDGE_RUN) begin
      if (r < 92) return ecss_pkg::KIND_INTAKE;
      if (r < 95) return ecss_pkg::KIND_EXHAUST;
      if (r < 97) return ecss_pkg::KIND_EVALUATE;
      if (r < 98) return ecss_pkg::KIND_STOP;
      if (r < 99) return ecss_pkg::KIND_LONG_TOOTH;
      return ecss_pkg::KIND_MID_CHECK;
    end
    if (r < 28) return ecss_pkg::KIND_INTAKE;
    if (r < 52) return ecss_pkg::KIND_EXHAUST;
    if (r < 57) return ecss_pkg::KIND_LONG_TOOTH;
    if (r < 72) return ecss_pkg::KIND_EVALUATE;
    if (r < 82) return ecss_pkg::KIND_STOP;
    if (r < 87) return ecss_pkg::KIND_CRANK_OFF;
    if (r < 97) return ecss_pkg::KIND_MID_CHECK;
    return KIND_UNUSED;
  endfunction

  function automatic logic [ANGLE_W-1:0] pick_angle(logic [2:0] kind);
    int r;
    r = $urandom_range(0, 9);
    // most angles inside the uncapped range; edges also hit the rounding boundary
    if (r < 6 || (r < 8 && kind != ecss_pkg::KIND_INTAKE && kind != ecss_pkg::KIND_EXHAUST))
      return 16'($urandom_range(0, 46271));
    if (r < 8)
      return 16'(384 * $urandom_range(0, 120) + 191 + $urandom_range(0, 1));
    return 16'($urandom_range(0, 65535));
  endfunction

  task automatic run_mix(mix_t mix, int count);
    logic [2:0] kind;
    logic [3:0] flags;
    for (int i = 0; i < count; i++) begin
      kind  = pick_kind(mix);
      flags = 4'($urandom_range(0, 15));
      if (mix == MIX_EDGE_RUN) begin
        flags[1:0] = 2'b00;   // keep the counts running towards the wrap
        if (i == 40) hold_req = 1'b1;
      end else if (kind == ecss_pkg::KIND_MID_CHECK && $urandom_range(0, 1) == 0) begin
        flags[1:0] = 2'b00;
      end
      send_item(kind, pick_angle(kind), flags, 1'b0, '0);
    end
  endtask

  function automatic logic [REFS_W-1:0] ref_grid();
    logic [REFS_W-1:0] v;
    for (int i = 0; i < REFS_PACKED; i++)
      v[REF_W*i +: REF_W] = REF_W'(6 * $urandom_range(0, 120));
    return v;
  endfunction

  // result side: random back-pressure plus one long hold on request
  initial begin
    int rx_cycles;
    rx_cycles = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycles++;
      if (rx_cycles % 64 == 0)
        rx_calm = ($urandom_range(0, 3) == 0);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        out_ready <= 1'b1;
      end else if (!rx_calm && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len()) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    cam_status_t want;
    if (rst_n && out_valid && out_ready) begin
      n_results++;
      if (pending_status.size() == 0) begin
        flag_mismatch("result item with nothing expected");
      end else begin
        want = pending_status.pop_front();
        compare_field("edge_angle_index", 8'(out_edge_angle_index), 8'(want.edge_idx));
        compare_field("edge_matched", 8'(out_edge_matched), 8'(want.matched));
        compare_field("intake_match_count", out_intake_match_count, want.intake_cnt);
        compare_field("exhaust_match_count", out_exhaust_match_count, want.exhaust_cnt);
        compare_field("sync_accurate", 8'(out_sync_accurate), 8'(want.accurate));
        compare_field("sync_coarse", 8'(out_sync_coarse), 8'(want.coarse));
        compare_field("accurate_rise", 8'(out_accurate_rise), 8'(want.accurate_rise));
        compare_field("coarse_rise", 8'(out_coarse_rise), 8'(want.coarse_rise));
        compare_field("stop_valid", 8'(out_stop_valid), 8'(want.stop_valid));
        compare_field("stop_seen", 8'(out_stop_seen), 8'(want.stop_seen));
        compare_field("stop_position", out_stop_position, want.stop_pos);
      end
    end
  end

  always @(posedge clk) begin : watchdog
    int quiet;
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      quiet = 0;
    else
      quiet++;
    if (quiet >= IDLE_LIMIT) begin
      $display("engine_cam_sync_status: mismatch");
      $finish;
    end
  end

  initial begin
    rst_n            = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = ecss_pkg::REG_MATCH_WINDOW;
    cfg_data         = '0;
    in_valid         = 1'b0;
    in_kind          = ecss_pkg::KIND_INTAKE;
    in_angle_raw     = '0;
    in_crank_fault   = 1'b0;
    in_position_ok   = 1'b0;
    in_inhibit_fault = 1'b0;
    in_force_unsync  = 1'b0;
    win_cfg = '0; acc_thr_cfg = '0; crs_thr_cfg = '0;
    intake_refs_cfg = '0; exhaust_refs_cfg = '0;
    intake_cnt = '0; exhaust_cnt = '0; long_tooth = 1'b0; acc_flag = 1'b0;
    crs_flag = 1'b0; stop_ok = 1'b0; stop_hit = 1'b0; acc_was = 1'b0; crs_was = 1'b0;
    stop_pos = '0;

    dir_steps = '{
      // reset settings: window 0 never matches, zero thresholds always sync
      '{1'b0, '0, '0, ecss_pkg::KIND_INTAKE, 16'h0000, 4'b0000, 1'b1, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_INTAKE, 16'hFFFF, 4'b0000, 1'b1,
        {7'd120, 1'b0, 16'd0, 6'b000000, 8'd0}},
      '{1'b0, '0, '0, ecss_pkg::KIND_STOP, 16'hFFFF, 4'b0100, 1'b1,
        {7'd0, 1'b0, 16'd0, 6'b000001, 8'd240}},
      '{1'b0, '0, '0, ecss_pkg::KIND_EVALUATE, 16'h0000, 4'b0000, 1'b1,
        {7'd0, 1'b0, 16'd0, 6'b111101, 8'd240}},
      '{1'b0, '0, '0, ecss_pkg::KIND_EVALUATE, 16'h0000, 4'b0000, 1'b1,
        {7'd0, 1'b0, 16'd0, 6'b110001, 8'd240}},
      '{1'b0, '0, '0, ecss_pkg::KIND_STOP, 16'h00BF, 4'b0100, 1'b0, 38'd0},
      '{1'b0, '0, '0, KIND_UNUSED, 16'hFFFF, 4'b1111, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_CRANK_OFF, 16'h0000, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_EVALUATE, 16'h0000, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_MID_CHECK, 16'h0000, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_MID_CHECK, 16'h0000, 4'b0010, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_EVALUATE, 16'h0000, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_MID_CHECK, 16'h0000, 4'b0001, 1'b0, 38'd0},
      // wide window; intake refs at both ends of the angle range, exhaust refs at 1023, beyond it
      '{1'b1, ecss_pkg::REG_MATCH_WINDOW, 60'd255,
        ecss_pkg::KIND_INTAKE, 16'h0, 4'h0, 1'b0, 38'd0},
      '{1'b1, ecss_pkg::REG_ACCURATE_THRESHOLD, 60'd3,
        ecss_pkg::KIND_INTAKE, 16'h0, 4'h0, 1'b0, 38'd0},
      '{1'b1, ecss_pkg::REG_COARSE_THRESHOLD, 60'd2,
        ecss_pkg::KIND_INTAKE, 16'h0, 4'h0, 1'b0, 38'd0},
      '{1'b1, ecss_pkg::REG_INTAKE_REFS, {10'd720, 50'd0},
        ecss_pkg::KIND_INTAKE, 16'h0, 4'h0, 1'b0, 38'd0},
      '{1'b1, ecss_pkg::REG_EXHAUST_REFS, {60{1'b1}},
        ecss_pkg::KIND_INTAKE, 16'h0, 4'h0, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_INTAKE, 16'h0000, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_INTAKE, 16'hFFFF, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_EXHAUST, 16'hFFFF, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_EXHAUST, 16'h0000, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_EVALUATE, 16'h0000, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_LONG_TOOTH, 16'h0000, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_EVALUATE, 16'h0000, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_STOP, 16'h1234, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_STOP, 16'h1234, 4'b1100, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_STOP, 16'hB400, 4'b0100, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_CRANK_OFF, 16'h0000, 4'b0000, 1'b0, 38'd0},
      '{1'b0, '0, '0, ecss_pkg::KIND_EVALUATE, 16'h0000, 4'b0000, 1'b0, 38'd0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_reg)
        write_reg(dir_steps[i].reg_idx, dir_steps[i].reg_val);
      else
        send_item(dir_steps[i].kind, dir_steps[i].angle, dir_steps[i].flags,
                  dir_steps[i].typed, dir_steps[i].want);
    end

    write_reg(ecss_pkg::REG_MATCH_WINDOW, REFS_W'($urandom_range(0, 255)));
    write_reg(ecss_pkg::REG_ACCURATE_THRESHOLD, REFS_W'($urandom_range(0, 10)));
    write_reg(ecss_pkg::REG_COARSE_THRESHOLD, REFS_W'($urandom_range(0, 6)));
    write_reg(ecss_pkg::REG_INTAKE_REFS, REFS_W'({$urandom, $urandom}));
    write_reg(ecss_pkg::REG_EXHAUST_REFS, REFS_W'({$urandom, $urandom}));
    run_mix(MIX_GENERAL, 100);

    // every edge matches, so the intake count runs through its wrap
    write_reg(ecss_pkg::REG_MATCH_WINDOW, 60'd255);
    write_reg(ecss_pkg::REG_ACCURATE_THRESHOLD, 60'd255);
    write_reg(ecss_pkg::REG_COARSE_THRESHOLD, 60'd200);
    write_reg(ecss_pkg::REG_INTAKE_REFS,
              {10'd720, 10'd600, 10'd450, 10'd300, 10'd150, 10'd0});
    write_reg(ecss_pkg::REG_EXHAUST_REFS,
              {10'd0, 10'd150, 10'd300, 10'd450, 10'd600, 10'd720});
    send_item(ecss_pkg::KIND_CRANK_OFF, 16'h0000, 4'b0000, 1'b0, '0);
    run_mix(MIX_EDGE_RUN, 300);

    // exact hits only
    write_reg(ecss_pkg::REG_MATCH_WINDOW, 60'd1);
    write_reg(ecss_pkg::REG_ACCURATE_THRESHOLD, 60'd1);
    write_reg(ecss_pkg::REG_COARSE_THRESHOLD, 60'd0);
    write_reg(ecss_pkg::REG_INTAKE_REFS, ref_grid());
    write_reg(ecss_pkg::REG_EXHAUST_REFS, ref_grid());
    run_mix(MIX_GENERAL, 50);

    settle_pipeline();
    repeat (8) @(posedge clk);
    $display("covered %0d items, %0d results checked, %0d matched edges, %0d count wraps",
             n_items, n_results, n_matched, n_wraps);
    $display("accurate sync rose %0d times; %0d field mismatches", n_acc_rise, fail_count);
    if (fail_count == 0)
      $display("engine_cam_sync_status: match");
    else
      $display("engine_cam_sync_status: mismatch");
    $finish;
  end

endmodule
`default_nettype wire
